/* design/cmap_pkg.sv */
package cmap_pkg;

    // Sizing of the table and of the sample
    localparam int TABLE_DEPTH  = 256;
    localparam int SAMPLE_WIDTH = 16;

    // Fixed field widths
    localparam int CHAN_W   = 8;
    localparam int COLOR_W  = 3 * CHAN_W;
    localparam int INDEX_W  = 8;
    localparam int ZMIN_W   = 16;
    localparam int SCALE_W  = 25;
    localparam int ENTRY_W  = 9;
    localparam int FRAC_W   = 16;

    // Derived widths
    localparam int ADDR_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW       = $clog2(TABLE_DEPTH + 1);
    localparam int D_W      = ((SAMPLE_WIDTH > ZMIN_W) ? SAMPLE_WIDTH : ZMIN_W) + 1;
    localparam int P_W      = D_W + SCALE_W + 1;
    localparam int IP_W     = P_W - FRAC_W;

    // Input tdata layout, lowest field first
    localparam int SAMPLE_LSB = 0;
    localparam int INDEX_LSB  = SAMPLE_LSB + SAMPLE_WIDTH;
    localparam int RED_LSB    = INDEX_LSB + INDEX_W;
    localparam int GREEN_LSB  = RED_LSB + CHAN_W;
    localparam int BLUE_LSB   = GREEN_LSB + CHAN_W;
    localparam int S_DATA_W   = ((BLUE_LSB + CHAN_W + 7) / 8) * 8;
    localparam int M_DATA_W   = COLOR_W;

    // Opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_MAP   = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_MIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 2'd2;

    // Reset values of the configuration
    localparam logic [SCALE_W-1:0] SCALE_RESET   = 25'd256;
    localparam logic [ENTRY_W-1:0] ENTRIES_RESET = 9'd256;

    typedef struct packed {
        logic signed [ZMIN_W-1:0] z_min;
        logic [SCALE_W-1:0]       scale;
        logic [ENTRY_W-1:0]       entries;
    } cmap_cfg_t;

    // Table access request handed from the position pipe to the lookup stage
    typedef struct packed {
        logic               is_map;
        logic               wr_ok;
        logic [ADDR_W-1:0]  wr_addr;
        logic [COLOR_W-1:0] wr_data;
        logic [ADDR_W-1:0]  rd_lo;
        logic [ADDR_W-1:0]  rd_hi;
        logic [CHAN_W-1:0]  frac;
    } cmap_req_t;

endpackage

/* design/cmap_ram.sv */
module cmap_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 24,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Two registered read ports, held while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* design/cmap_position.sv */
module cmap_position (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  cmap_pkg::cmap_cfg_t                  cfg,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 in_opcode,
    input  logic [cmap_pkg::SAMPLE_WIDTH-1:0]    in_sample,
    input  logic [cmap_pkg::INDEX_W-1:0]         in_index,
    input  logic [cmap_pkg::COLOR_W-1:0]         in_color,
    output logic                                 req_valid,
    input  logic                                 req_ready,
    output cmap_pkg::cmap_req_t                  req
);

    logic                                    v1_reg;
    logic                                    v2_reg;
    logic                                    op1_reg;
    logic                                    op2_reg;
    logic signed [cmap_pkg::D_W-1:0]         d1_reg;
    logic signed [cmap_pkg::D_W-1:0]         d_next;
    logic signed [cmap_pkg::P_W-1:0]         p2_reg;
    logic signed [cmap_pkg::P_W-1:0]         p_next;
    logic [cmap_pkg::INDEX_W-1:0]            idx1_reg;
    logic [cmap_pkg::INDEX_W-1:0]            idx2_reg;
    logic [cmap_pkg::COLOR_W-1:0]            col1_reg;
    logic [cmap_pkg::COLOR_W-1:0]            col2_reg;
    logic                                    s2_ready;
    logic                                    take1;
    logic                                    take2;

    logic [cmap_pkg::NW-1:0]                 n;
    logic [cmap_pkg::NW-1:0]                 nm1;
    logic [cmap_pkg::IP_W-1:0]               ipart;
    logic [cmap_pkg::ADDR_W-1:0]             lo;
    logic [cmap_pkg::NW-1:0]                 lo_p1;
    logic [cmap_pkg::CHAN_W-1:0]             frac;

    // Stage ready chain
    assign s2_ready = !v2_reg || req_ready;
    assign in_ready = !v1_reg || s2_ready;
    assign take1    = in_valid && in_ready;
    assign take2    = v1_reg && s2_ready;

    // Offset against z_min, then scale into Q.16 position (17 x 26 bit signed product)
    assign d_next = cmap_pkg::D_W'($signed(in_sample)) - cmap_pkg::D_W'(cfg.z_min);
    assign p_next = cmap_pkg::P_W'(d1_reg) * cmap_pkg::P_W'($signed({1'b0, cfg.scale}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                v1_reg <= in_valid;
            end
            if (s2_ready) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take1) begin
            op1_reg  <= in_opcode;
            d1_reg   <= d_next;
            idx1_reg <= in_index;
            col1_reg <= in_color;
        end
        if (take2) begin
            op2_reg  <= op1_reg;
            p2_reg   <= p_next;
            idx2_reg <= idx1_reg;
            col2_reg <= col1_reg;
        end
    end

    // Clamp the position and pick the two neighboring entries
    always_comb begin
        if (cfg.entries == '0) begin
            n = cmap_pkg::NW'(1);
        end else if (32'(cfg.entries) > cmap_pkg::TABLE_DEPTH) begin
            n = cmap_pkg::NW'(cmap_pkg::TABLE_DEPTH);
        end else begin
            n = cmap_pkg::NW'(cfg.entries);
        end
        nm1   = n - cmap_pkg::NW'(1);
        ipart = p2_reg[cmap_pkg::P_W-1:cmap_pkg::FRAC_W];

        if (p2_reg[cmap_pkg::P_W-1]) begin
            lo   = '0;
            frac = '0;
        end else if (ipart >= cmap_pkg::IP_W'(nm1)) begin
            lo   = cmap_pkg::ADDR_W'(nm1);
            frac = '0;
        end else begin
            lo   = cmap_pkg::ADDR_W'(ipart);
            frac = p2_reg[cmap_pkg::FRAC_W-1:cmap_pkg::FRAC_W-cmap_pkg::CHAN_W];
        end
        lo_p1 = cmap_pkg::NW'(lo) + cmap_pkg::NW'(1);

        req.is_map  = (op2_reg == cmap_pkg::OP_MAP);
        req.wr_ok   = (32'(idx2_reg) < cmap_pkg::TABLE_DEPTH);
        req.wr_addr = cmap_pkg::ADDR_W'(idx2_reg);
        req.wr_data = col2_reg;
        req.rd_lo   = lo;
        req.rd_hi   = (lo_p1 < n) ? cmap_pkg::ADDR_W'(lo_p1) : lo;
        req.frac    = frac;
    end

    assign req_valid = v2_reg;

    // Lower entry always lies inside the entries in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        (req_valid && req.is_map) |-> (cmap_pkg::NW'(req.rd_lo) < n))
        else $error("lower table address beyond entries in use");

    // Upper entry is the lower one or the next one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (req_valid && req.is_map) |->
            ((req.rd_hi == req.rd_lo) ||
             (cmap_pkg::NW'(req.rd_hi) == cmap_pkg::NW'(req.rd_lo) + cmap_pkg::NW'(1))))
        else $error("upper table address not adjacent to lower");

endmodule

/* design/cmap_blend.sv */
module cmap_blend (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [cmap_pkg::CHAN_W-1:0]     in_frac,
    input  logic [cmap_pkg::COLOR_W-1:0]    rd_lo,
    input  logic [cmap_pkg::COLOR_W-1:0]    rd_hi,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [cmap_pkg::M_DATA_W-1:0]   out_data
);

    logic                            v3_reg;
    logic [cmap_pkg::CHAN_W-1:0]     frac_reg;
    logic                            vo_reg;
    logic [cmap_pkg::M_DATA_W-1:0]   data_reg;
    logic [cmap_pkg::M_DATA_W-1:0]   data_next;
    logic                            o_free;

    // lo*(256-f) + hi*f, rounded to nearest
    function automatic logic [cmap_pkg::CHAN_W-1:0] mix(
        input logic [cmap_pkg::CHAN_W-1:0] a,
        input logic [cmap_pkg::CHAN_W-1:0] b,
        input logic [cmap_pkg::CHAN_W-1:0] f
    );
        logic [16:0] acc;
        acc = 17'(a) * 17'(9'd256 - 9'(f)) + 17'(b) * 17'(f) + 17'd128;
        return acc[15:8];
    endfunction

    assign o_free   = !vo_reg || out_ready;
    assign in_ready = !v3_reg || o_free;

    // Output tdata: red lowest, then green, then blue
    always_comb begin
        data_next[7:0]   = mix(rd_lo[23:16], rd_hi[23:16], frac_reg);
        data_next[15:8]  = mix(rd_lo[15:8],  rd_hi[15:8],  frac_reg);
        data_next[23:16] = mix(rd_lo[7:0],   rd_hi[7:0],   frac_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                v3_reg <= in_valid;
            end
            if (o_free) begin
                vo_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            frac_reg <= in_frac;
        end
        if (v3_reg && o_free) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vo_reg;
    assign out_data  = data_reg;

endmodule

/* design/colormap_lookup_interpolate_top.sv */
// Path: an accepted map transfer passes the offset and scale registers, the table read and the output register.
// Throughput: one item per cycle while m_tready is high; each stage holds one item and stalls only when full.
// The table RAM is read and written in the same pipeline stage, so item order fixes
// what every read sees. Write items give no result and leave the pipe at that stage.
// Reset (aresetn low, synchronous) empties the pipeline and sets z_min 0, scale 256,
// entries in use 256; table contents stay undefined until written, with no clearing pass.
module colormap_lookup_interpolate_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // sample, entry_index, entry_red, entry_green, entry_blue
    input  logic [cmap_pkg::S_DATA_W-1:0]         s_tdata,
    // opcode
    input  logic [0:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // red, green, blue
    output logic [cmap_pkg::M_DATA_W-1:0]         m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cmap_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cmap_pkg::SCALE_W-1:0]          cfg_data
);

    cmap_pkg::cmap_cfg_t              cfg_reg;
    cmap_pkg::cmap_cfg_t              cfg_next;
    cmap_pkg::cmap_req_t              req;
    logic                             req_valid;
    logic                             req_ready;
    logic                             blend_ready;
    logic                             ram_we;
    logic                             ram_re;
    logic [cmap_pkg::COLOR_W-1:0]     rd_lo;
    logic [cmap_pkg::COLOR_W-1:0]     rd_hi;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                cmap_pkg::CFG_Z_MIN:   cfg_next.z_min   = cfg_data[cmap_pkg::ZMIN_W-1:0];
                cmap_pkg::CFG_SCALE:   cfg_next.scale   = cfg_data;
                cmap_pkg::CFG_ENTRIES: cfg_next.entries = cfg_data[cmap_pkg::ENTRY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.z_min   <= '0;
            cfg_reg.scale   <= cmap_pkg::SCALE_RESET;
            cfg_reg.entries <= cmap_pkg::ENTRIES_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Offset, scale and clamp
    cmap_position u_position (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_opcode (s_tuser[0]),
        .in_sample (s_tdata[cmap_pkg::INDEX_LSB-1:cmap_pkg::SAMPLE_LSB]),
        .in_index  (s_tdata[cmap_pkg::RED_LSB-1:cmap_pkg::INDEX_LSB]),
        .in_color  ({s_tdata[cmap_pkg::GREEN_LSB-1:cmap_pkg::RED_LSB],
                     s_tdata[cmap_pkg::BLUE_LSB-1:cmap_pkg::GREEN_LSB],
                     s_tdata[cmap_pkg::BLUE_LSB+cmap_pkg::CHAN_W-1:cmap_pkg::BLUE_LSB]}),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    // Table stage: a write leaves here, a map item reads both neighbors
    assign req_ready = !req.is_map || blend_ready;
    assign ram_we    = req_valid && !req.is_map && req.wr_ok;
    assign ram_re    = req_valid && req.is_map && blend_ready;

    cmap_ram #(
        .DEPTH (cmap_pkg::TABLE_DEPTH),
        .WIDTH (cmap_pkg::COLOR_W),
        .AW    (cmap_pkg::ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (req.wr_addr),
        .wdata   (req.wr_data),
        .re      (ram_re),
        .raddr_a (req.rd_lo),
        .raddr_b (req.rd_hi),
        .rdata_a (rd_lo),
        .rdata_b (rd_hi)
    );

    // Per-channel blend and output register
    cmap_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (req_valid && req.is_map),
        .in_ready  (blend_ready),
        .in_frac   (req.frac),
        .rd_lo     (rd_lo),
        .rd_hi     (rd_hi),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // One item at the table stage: never a write and a read together
    assert property (@(posedge aclk) disable iff (!aresetn) !(ram_we && ram_re))
        else $error("table write and read issued in the same cycle");

endmodule
